// ----- design/cbm_pkg.sv -----
// Shared types and constants for the cartridge bank mapper.
package cbm_pkg;

    localparam int unsigned ADDR_W     = 15;
    localparam int unsigned DATA_W     = 8;
    localparam int unsigned ROM_BANK_W = 9;
    localparam int unsigned RAM_BANK_W = 4;
    localparam int unsigned KIND_W     = 3;
    localparam int unsigned IN_TDATA_W  = 24;
    localparam int unsigned OUT_TDATA_W = 16;

    localparam logic [3:0] ENABLE_NIBBLE = 4'hA;
    localparam logic [7:0] ENABLE_BYTE   = 8'h0A;

    // Address window selected by write address bits 14:13.
    localparam logic [1:0] WIN_ENABLE = 2'b00;
    localparam logic [1:0] WIN_ROM    = 2'b01;
    localparam logic [1:0] WIN_RAM    = 2'b10;
    localparam logic [1:0] WIN_MODE   = 2'b11;

    typedef enum logic [KIND_W-1:0] {
        KIND_NONE = 3'd0,
        KIND_MBC1 = 3'd1,
        KIND_MBC2 = 3'd2,
        KIND_MBC3 = 3'd3,
        KIND_MBC5 = 3'd4
    } t_mapper_kind;

    typedef struct packed {
        logic                  large_ram_mode;
        logic                  ram_enabled;
        logic [RAM_BANK_W-1:0] ram_bank;
        logic [ROM_BANK_W-1:0] rom_bank;
    } t_bank_state;

endpackage

// ----- design/cartridge_bank_mapper.sv -----
// Top level of the cartridge bank mapper: configuration register and stream ports.
// Each transfer on the slave side is one CPU write to the ROM area; the block answers every
// write with one transfer on the master side carrying the bank mapping after that write. A
// write is taken into an input register, then applied to the bank registers and shown in
// the result register at the same edge, held off while the master side stalls a result;
// one write per cycle is sustained while the master side keeps up. The user must change
// the controller kind through the configuration channel only while no write is in flight;
// the block does not enforce this. Bank registers keep their values across a kind change.
module cartridge_bank_mapper (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [cbm_pkg::KIND_W-1:0]         i_cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // Fields from bit 0: write_address[14:0], write_data[22:15], zero fill[23].
    input  logic [cbm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // Fields from bit 0: rom_bank[8:0], ram_bank[12:9], ram_enabled[13],
    // large_ram_mode[14], zero fill[15].
    output logic [cbm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import cbm_pkg::*;

    logic [KIND_W-1:0] r_kind;
    t_bank_state       result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= KIND_NONE;
        end else if (i_cfg_valid) begin
            r_kind <= i_cfg_data;
        end
    end

    cbm_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_kind   (r_kind),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_addr   (s_axis_tdata[ADDR_W-1:0]),
        .i_data   (s_axis_tdata[ADDR_W+DATA_W-1:ADDR_W]),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (result)
    );

    assign m_axis_tdata = {1'b0, result};

endmodule

// ----- design/cbm_core.sv -----
// Input register, bank state registers with their update logic, and result register.
module cbm_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [cbm_pkg::KIND_W-1:0]  i_kind,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [cbm_pkg::ADDR_W-1:0]  i_addr,
    input  logic [cbm_pkg::DATA_W-1:0]  i_data,
    output logic                        o_valid,
    input  logic                        i_ready,
    output cbm_pkg::t_bank_state        o_result
);
    import cbm_pkg::*;

    logic                 r_in_valid;
    logic [ADDR_W-1:0]    r_addr;
    logic [DATA_W-1:0]    r_data;
    logic                 r_out_valid;
    t_bank_state          r_out;
    t_bank_state          r_state;
    t_bank_state          n_state;
    logic                 advance;
    logic [1:0]           win;

    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;
    assign o_valid = r_out_valid;
    assign o_result = r_out;
    assign win = r_addr[14:13];

    always_comb begin
        n_state = r_state;
        unique case (i_kind)
            KIND_MBC1: begin
                unique case (win)
                    WIN_ENABLE: n_state.ram_enabled = (r_data[3:0] == ENABLE_NIBBLE);
                    WIN_ROM: begin
                        n_state.rom_bank = {1'b0, 1'b0, r_state.rom_bank[6:5], r_data[4:0]};
                    end
                    WIN_RAM: begin
                        if (!r_state.large_ram_mode) begin
                            n_state.rom_bank = {2'b00, r_data[1:0], r_state.rom_bank[4:0]};
                        end else begin
                            n_state.ram_bank = {2'b00, r_data[1:0]};
                        end
                    end
                    WIN_MODE: n_state.large_ram_mode = r_data[0];
                    default: n_state = r_state;
                endcase
            end
            KIND_MBC2: begin
                if (r_addr[8]) begin
                    if (win == WIN_ENABLE) begin
                        n_state.ram_enabled = !r_state.ram_enabled;
                    end else if (win == WIN_ROM && !r_addr[12]) begin
                        n_state.rom_bank = {5'd0, r_data[3:0]};
                    end
                end
            end
            KIND_MBC3: begin
                unique case (win)
                    WIN_ENABLE: n_state.ram_enabled = (r_data[3:0] == ENABLE_NIBBLE);
                    WIN_ROM:    n_state.rom_bank = {2'b00, r_data[6:0]};
                    WIN_RAM:    n_state.ram_bank = {2'b00, r_data[1:0]};
                    default:    n_state = r_state;
                endcase
            end
            KIND_MBC5: begin
                unique case (win)
                    WIN_ENABLE: n_state.ram_enabled = (r_data == ENABLE_BYTE);
                    WIN_ROM: begin
                        if (!r_addr[12]) begin
                            n_state.rom_bank = {r_state.rom_bank[8], r_data};
                        end else begin
                            n_state.rom_bank = {r_data[0], r_state.rom_bank[7:0]};
                        end
                    end
                    WIN_RAM:    n_state.ram_bank = r_data[3:0];
                    default:    n_state = r_state;
                endcase
            end
            default: n_state = r_state;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_addr <= i_addr;
            r_data <= i_data;
        end
        if (advance) begin
            r_out <= n_state;
        end
    end

endmodule
